// File: hdl/mcmf_pkg.sv
package mcmf_pkg;

   // Widths of the pixel channels, the packed color and the reported count.
   localparam int CHAN_W       = 8;
   localparam int COLOR_W      = 3 * CHAN_W;
   localparam int MODE_COUNT_W = 22;

   // Bit positions of the channels inside the packed color.
   localparam int BLUE_LSB  = 16;
   localparam int GREEN_LSB = 8;
   localparam int RED_LSB   = 0;

   // Controller states.
   typedef enum logic [1:0] {
      ST_RUN,
      ST_SCAN,
      ST_HOLD
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic count_pixel;
      logic scan_start;
      logic scan_step;
      logic load_out;
      logic clear_table;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_last;
      logic out_free;
   } status_type;

endpackage

// File: hdl/mcmf_channels.sv
// Pixel channel: one pixel per transfer.
interface mcmf_req_if;
   logic                        valid;
   logic                        ready;
   logic [mcmf_pkg::CHAN_W-1:0] blue;
   logic [mcmf_pkg::CHAN_W-1:0] green;
   logic [mcmf_pkg::CHAN_W-1:0] red;
   logic                        in_mask;
   logic                        last_pixel;

   modport source (output valid, blue, green, red, in_mask, last_pixel, input ready);
   modport sink   (input valid, blue, green, red, in_mask, last_pixel, output ready);
endinterface

// Result channel: one mode result per region.
interface mcmf_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [mcmf_pkg::CHAN_W-1:0]       mode_blue;
   logic [mcmf_pkg::CHAN_W-1:0]       mode_green;
   logic [mcmf_pkg::CHAN_W-1:0]       mode_red;
   logic [mcmf_pkg::MODE_COUNT_W-1:0] mode_count;
   logic                              table_overflow;

   modport source (output valid, mode_blue, mode_green, mode_red, mode_count,
                   table_overflow, input ready);
   modport sink   (input valid, mode_blue, mode_green, mode_red, mode_count,
                   table_overflow, output ready);
endinterface

// File: hdl/mcmf_ctrl.sv
module mcmf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_in_mask,
   input  logic                  req_last_pixel,
   input  mcmf_pkg::status_type  status,
   output logic                  req_ready,
   output mcmf_pkg::cmd_type     cmd
);

   mcmf_pkg::state_type state_ff;
   mcmf_pkg::state_type state_in;
   logic                pixel_xfer;

   assign req_ready  = (state_ff == mcmf_pkg::ST_RUN);
   assign pixel_xfer = req_valid && req_ready;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcmf_pkg::ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state: a last pixel starts the scan, the scan ends in a wait for the
   // output register.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mcmf_pkg::ST_RUN: begin
            if (pixel_xfer && req_last_pixel) begin
               state_in = mcmf_pkg::ST_SCAN;
            end
         end
         mcmf_pkg::ST_SCAN: begin
            if (status.scan_last) begin
               state_in = mcmf_pkg::ST_HOLD;
            end
         end
         mcmf_pkg::ST_HOLD: begin
            if (status.out_free) begin
               state_in = mcmf_pkg::ST_RUN;
            end
         end
         default: begin
            state_in = mcmf_pkg::ST_RUN;
         end
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd = '0;
      case (state_ff)
         mcmf_pkg::ST_RUN: begin
            cmd.count_pixel = pixel_xfer && req_in_mask;
            cmd.scan_start  = pixel_xfer && req_last_pixel;
         end
         mcmf_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         mcmf_pkg::ST_HOLD: begin
            cmd.load_out    = status.out_free;
            cmd.clear_table = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: hdl/mcmf_datapath.sv
module mcmf_datapath #(
   parameter int TABLE_ENTRIES = 32,
   parameter int COUNT_BITS    = 22
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mcmf_pkg::cmd_type                 cmd,
   output mcmf_pkg::status_type              status,
   input  logic [mcmf_pkg::CHAN_W-1:0]       pix_blue,
   input  logic [mcmf_pkg::CHAN_W-1:0]       pix_green,
   input  logic [mcmf_pkg::CHAN_W-1:0]       pix_red,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [mcmf_pkg::CHAN_W-1:0]       mode_blue,
   output logic [mcmf_pkg::CHAN_W-1:0]       mode_green,
   output logic [mcmf_pkg::CHAN_W-1:0]       mode_red,
   output logic [mcmf_pkg::MODE_COUNT_W-1:0] mode_count,
   output logic                              table_overflow
);

   localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int USED_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // Table lanes: one color, count and valid bit per entry.
   logic [mcmf_pkg::COLOR_W-1:0] color_ff [TABLE_ENTRIES];
   logic [COUNT_BITS-1:0]        count_ff [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0]     valid_ff;
   logic [TABLE_ENTRIES-1:0]     hit;

   logic [USED_W-1:0]            used_ff;
   logic                         overflow_ff;

   // Scan state.
   logic [IDX_W-1:0]             scan_idx_ff;
   logic [COUNT_BITS-1:0]        best_count_ff;
   logic [mcmf_pkg::COLOR_W-1:0] best_color_ff;

   // Output register.
   logic                              out_valid_ff;
   logic [mcmf_pkg::COLOR_W-1:0]      out_color_ff;
   logic [mcmf_pkg::MODE_COUNT_W-1:0] out_count_ff;
   logic                              out_overflow_ff;

   logic [mcmf_pkg::COLOR_W-1:0]                  pix_color;
   logic                                          any_hit;
   logic                                          table_full;
   logic                                          do_insert;
   logic [IDX_W-1:0]                              ins_idx;
   logic [COUNT_BITS+mcmf_pkg::MODE_COUNT_W-1:0]  best_count_ext;

   assign pix_color  = {pix_blue, pix_green, pix_red};
   assign any_hit    = |hit;
   assign table_full = (used_ff == USED_W'(TABLE_ENTRIES));
   assign do_insert  = cmd.count_pixel && !any_hit && !table_full;
   assign ins_idx    = used_ff[IDX_W-1:0];

   // Associative match and per-entry update, all lanes in parallel.
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_lane
      assign hit[i] = valid_ff[i] && (color_ff[i] == pix_color);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (cmd.clear_table) begin
            valid_ff[i] <= 1'b0;
         end else if (do_insert && (ins_idx == IDX_W'(i))) begin
            valid_ff[i] <= 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (do_insert && (ins_idx == IDX_W'(i))) begin
            color_ff[i] <= pix_color;
            count_ff[i] <= COUNT_BITS'(1);
         end else if (cmd.count_pixel && hit[i] && (count_ff[i] != COUNT_MAX)) begin
            count_ff[i] <= count_ff[i] + COUNT_BITS'(1);
         end
      end
   end

   // Fill count and overflow flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         overflow_ff <= 1'b0;
      end else if (cmd.clear_table) begin
         used_ff     <= '0;
         overflow_ff <= 1'b0;
      end else if (cmd.count_pixel && !any_hit) begin
         if (table_full) begin
            overflow_ff <= 1'b1;
         end else begin
            used_ff <= used_ff + USED_W'(1);
         end
      end
   end

   // Maximum scan, one entry per cycle in insertion order; only a strictly
   // greater count replaces the best, so ties keep the earlier color.
   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         scan_idx_ff   <= '0;
         best_count_ff <= '0;
         best_color_ff <= '0;
      end else if (cmd.scan_step) begin
         scan_idx_ff <= scan_idx_ff + IDX_W'(1);
         if (valid_ff[scan_idx_ff] && (count_ff[scan_idx_ff] > best_count_ff)) begin
            best_count_ff <= count_ff[scan_idx_ff];
            best_color_ff <= color_ff[scan_idx_ff];
         end
      end
   end

   assign best_count_ext = {{mcmf_pkg::MODE_COUNT_W{1'b0}}, best_count_ff};

   // Output register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_color_ff    <= best_color_ff;
         out_count_ff    <= best_count_ext[mcmf_pkg::MODE_COUNT_W-1:0];
         out_overflow_ff <= overflow_ff;
      end
   end

   assign status.scan_last = (scan_idx_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign status.out_free  = !out_valid_ff || rsp_ready;

   assign rsp_valid      = out_valid_ff;
   assign mode_blue      = out_color_ff[mcmf_pkg::BLUE_LSB +: mcmf_pkg::CHAN_W];
   assign mode_green     = out_color_ff[mcmf_pkg::GREEN_LSB +: mcmf_pkg::CHAN_W];
   assign mode_red       = out_color_ff[mcmf_pkg::RED_LSB +: mcmf_pkg::CHAN_W];
   assign mode_count     = out_count_ff;
   assign table_overflow = out_overflow_ff;

   // The fill count never passes the table size.
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(TABLE_ENTRIES))
      else $error("fill count exceeds table size");

   // Stored colors are distinct, so a pixel matches at most one entry.
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.count_pixel |-> $onehot0(hit))
      else $error("pixel matched more than one entry");

   // Clearing empties the table and drops the overflow flag.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_table |=> (used_ff == '0) && !overflow_ff && (valid_ff == '0))
      else $error("table not empty after clear");

   // A new result is never loaded over one that is still waiting.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!out_valid_ff || rsp_ready))
      else $error("result overwritten before transfer");

endmodule

// File: hdl/masked_color_mode_finder.sv
// Masked color mode finder.
// Pixels arrive on req_chan, one per transfer, as blue, green and red channels
// with a mask bit and a last flag. Each masked pixel is matched against a table
// of up to TABLE_ENTRIES distinct colors; a hit bumps a saturating count, a miss
// inserts the color, and a miss on a full table sets the overflow flag.
// Outside the scan and the wait for the output register, pixels are taken
// at one per cycle; matching and update happen in the cycle of the transfer,
// across all table entries in parallel. A last_pixel transfer starts a scan
// of the table, one entry per cycle; once the scan is over and the output
// register is free, the result is loaded and shows on rsp_chan the cycle
// after. No pixels are taken during the scan. The table is emptied when the
// result is loaded, and pixels of the next region are taken at once.
// The result waits in its output register while the receiver stalls; pixels
// keep flowing, and only after the next region's scan does the block stop
// taking pixels until the previous result has been transferred.
// An empty mask gives color 0 with count 0. Ties go to the earliest inserted
// color. Reset empties the table and drops any pending result.
module masked_color_mode_finder #(
   parameter int TABLE_ENTRIES = 32,
   parameter int COUNT_BITS    = 22
) (
   input logic        clock,
   input logic        reset,
   mcmf_req_if.sink   req_chan,
   mcmf_rsp_if.source rsp_chan
);

   mcmf_pkg::cmd_type    cmd;
   mcmf_pkg::status_type status;

   mcmf_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_in_mask    (req_chan.in_mask),
      .req_last_pixel (req_chan.last_pixel),
      .status         (status),
      .req_ready      (req_chan.ready),
      .cmd            (cmd)
   );

   mcmf_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .COUNT_BITS    (COUNT_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .pix_blue       (req_chan.blue),
      .pix_green      (req_chan.green),
      .pix_red        (req_chan.red),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .mode_blue      (rsp_chan.mode_blue),
      .mode_green     (rsp_chan.mode_green),
      .mode_red       (rsp_chan.mode_red),
      .mode_count     (rsp_chan.mode_count),
      .table_overflow (rsp_chan.table_overflow)
   );

endmodule

// File: sim/mcmf_checker.sv
`timescale 1ns / 1ps

// Watches the pixel and result channels of the mode finder, keeps its own copy
// of the color table, and compares every result with the one predicted for the
// oldest region still waiting.
module mcmf_checker #(
   parameter int TABLE_ENTRIES = 32,
   parameter int COUNT_BITS    = 22
) (
   input  logic clock,
   input  logic reset,
   mcmf_req_if  req_chan,
   mcmf_rsp_if  rsp_chan,
   output int   mismatch_count,
   output int   results_pending,
   output int   pixels_seen,
   output int   regions_checked,
   output int   overflow_regions
);

   typedef struct packed {
      logic [mcmf_pkg::CHAN_W-1:0]       blue;
      logic [mcmf_pkg::CHAN_W-1:0]       green;
      logic [mcmf_pkg::CHAN_W-1:0]       red;
      logic [mcmf_pkg::MODE_COUNT_W-1:0] count;
      logic                              overflow;
   } mode_rec_type;

   // Predicted color table: entries below colors_held are in use, in insertion order.
   logic [mcmf_pkg::COLOR_W-1:0] color_tab [TABLE_ENTRIES];
   logic [COUNT_BITS-1:0]        count_tab [TABLE_ENTRIES];
   int                           colors_held;
   logic                         table_overran;

   // Mode results of finished regions that have not been transferred yet.
   mode_rec_type modes_due [$];

   initial begin
      mismatch_count   = 0;
      results_pending  = 0;
      pixels_seen      = 0;
      regions_checked  = 0;
      overflow_regions = 0;
   end

   function automatic void empty_table();
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         color_tab[i] = '0;
         count_tab[i] = '0;
      end
      colors_held   = 0;
      table_overran = 1'b0;
   endfunction

   // A hit bumps the count unless it is already at its ceiling; a miss takes
   // the next free entry, or marks the overflow when the table is full.
   function automatic void tally_color(input logic [mcmf_pkg::COLOR_W-1:0] color);
      bit found;
      found = 1'b0;
      for (int i = 0; i < colors_held; i++) begin
         if (!found && color_tab[i] == color) begin
            found = 1'b1;
            if (count_tab[i] != '1) begin
               count_tab[i] = count_tab[i] + 1'b1;
            end
         end
      end
      if (!found) begin
         if (colors_held < TABLE_ENTRIES) begin
            color_tab[colors_held] = color;
            count_tab[colors_held] = COUNT_BITS'(1);
            colors_held++;
         end else begin
            table_overran = 1'b1;
         end
      end
   endfunction

   // Only a strictly larger count displaces the best so far, so ties go to the
   // color inserted first. An empty table leaves color 0 with count 0.
   function automatic mode_rec_type take_mode();
      logic [mcmf_pkg::COLOR_W-1:0] best_color;
      logic [31:0]                  best_count;
      mode_rec_type                 rec;
      best_color = '0;
      best_count = 0;
      for (int i = 0; i < colors_held; i++) begin
         if (count_tab[i] > best_count) begin
            best_count = count_tab[i];
            best_color = color_tab[i];
         end
      end
      rec.blue     = best_color[mcmf_pkg::BLUE_LSB +: mcmf_pkg::CHAN_W];
      rec.green    = best_color[mcmf_pkg::GREEN_LSB +: mcmf_pkg::CHAN_W];
      rec.red      = best_color[mcmf_pkg::RED_LSB +: mcmf_pkg::CHAN_W];
      rec.count    = best_count[mcmf_pkg::MODE_COUNT_W-1:0];
      rec.overflow = table_overran;
      empty_table();
      return rec;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Predict on each pixel transfer, compare on each result transfer.
   always @(posedge clock) begin
      mode_rec_type want;
      if (reset) begin
         empty_table();
         modes_due.delete();
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            pixels_seen++;
            if (req_chan.in_mask) begin
               tally_color({req_chan.blue, req_chan.green, req_chan.red});
            end
            if (req_chan.last_pixel) begin
               want = take_mode();
               if (want.overflow) begin
                  overflow_regions++;
               end
               modes_due.insert(modes_due.size(), want);
            end
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (modes_due.size() == 0) begin
               report_mismatch("result with no region pending, color",
                               {rsp_chan.mode_blue, rsp_chan.mode_green, rsp_chan.mode_red}, 0);
            end else begin
               want = modes_due.pop_front();
               regions_checked++;
               if (rsp_chan.mode_blue !== want.blue) begin
                  report_mismatch("mode_blue", rsp_chan.mode_blue, want.blue);
               end
               if (rsp_chan.mode_green !== want.green) begin
                  report_mismatch("mode_green", rsp_chan.mode_green, want.green);
               end
               if (rsp_chan.mode_red !== want.red) begin
                  report_mismatch("mode_red", rsp_chan.mode_red, want.red);
               end
               if (rsp_chan.mode_count !== want.count) begin
                  report_mismatch("mode_count", rsp_chan.mode_count, want.count);
               end
               if (rsp_chan.table_overflow !== want.overflow) begin
                  report_mismatch("table_overflow", rsp_chan.table_overflow, want.overflow);
               end
            end
         end
      end
      results_pending <= modes_due.size();
   end

endmodule

// File: sim/masked_color_mode_finder_tb.sv
`timescale 1ns / 1ps

module masked_color_mode_finder_tb;

   localparam int TABLE_ENTRIES = 32;
   localparam int COUNT_BITS    = 22;
   localparam int PIXEL_TARGET  = 700;
   localparam int CALM_TAIL     = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   gaps_on = 1'b1;
   int   pixels_sent = 0;

   int mismatch_count;
   int results_pending;
   int pixels_seen;
   int regions_checked;
   int overflow_regions;

   mcmf_req_if req_chan ();
   mcmf_rsp_if rsp_chan ();

   masked_color_mode_finder #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .COUNT_BITS   (COUNT_BITS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   mcmf_checker #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .COUNT_BITS   (COUNT_BITS)
   ) mode_checker (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .rsp_chan        (rsp_chan),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending),
      .pixels_seen     (pixels_seen),
      .regions_checked (regions_checked),
      .overflow_regions(overflow_regions)
   );

   always #4 clock = ~clock;

   // Mostly uniform colors, now and then with channels forced to 00 or FF.
   function automatic logic [mcmf_pkg::COLOR_W-1:0] random_color();
      logic [mcmf_pkg::COLOR_W-1:0] color;
      color = mcmf_pkg::COLOR_W'($urandom);
      if ($urandom_range(0, 7) == 0) begin
         for (int c = 0; c < 3; c++) begin
            case ($urandom_range(0, 2))
               0: color[c*mcmf_pkg::CHAN_W +: mcmf_pkg::CHAN_W] = '0;
               1: color[c*mcmf_pkg::CHAN_W +: mcmf_pkg::CHAN_W] = '1;
               default: ;
            endcase
         end
      end
      return color;
   endfunction

   // Drive one pixel at the falling edge, maybe after an idle burst, and hold
   // it until the transfer; returns at the falling edge after the transfer.
   task automatic send_pixel(input logic [mcmf_pkg::COLOR_W-1:0] color, input logic mask,
                             input logic last, input int gap_pct);
      if (gaps_on && gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.blue       <= color[mcmf_pkg::BLUE_LSB +: mcmf_pkg::CHAN_W];
      req_chan.green      <= color[mcmf_pkg::GREEN_LSB +: mcmf_pkg::CHAN_W];
      req_chan.red        <= color[mcmf_pkg::RED_LSB +: mcmf_pkg::CHAN_W];
      req_chan.in_mask    <= mask;
      req_chan.last_pixel <= last;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      pixels_sent++;
   endtask

   // Result receiver: ready is high except for random stalls.
   initial begin
      rsp_chan.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (gaps_on && $urandom_range(0, 7) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   // Stimulus.
   initial begin
      logic [mcmf_pkg::COLOR_W-1:0] palette [8];
      logic [mcmf_pkg::COLOR_W-1:0] anchor;
      int                           kind;
      int                           span;
      int                           colors;
      int                           gap_pct;
      int                           mask_pct;

      req_chan.valid      = 1'b0;
      req_chan.blue       = '0;
      req_chan.green      = '0;
      req_chan.red        = '0;
      req_chan.in_mask    = 1'b0;
      req_chan.last_pixel = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty mask: a lone unmasked last pixel gives color 0 with count 0.
      send_pixel(24'hFFFFFF, 1'b0, 1'b1, 20);
      // A single masked pixel at the top of every channel.
      send_pixel(24'hFFFFFF, 1'b1, 1'b1, 20);
      // Tie between black and a second color; the earlier insertion wins and the
      // unmasked pixel in between is not counted.
      send_pixel(24'h000000, 1'b1, 1'b0, 20);
      send_pixel(24'h123456, 1'b1, 1'b0, 20);
      send_pixel(24'h123456, 1'b1, 1'b0, 20);
      send_pixel(24'hFFFFFF, 1'b0, 1'b0, 20);
      send_pixel(24'h000000, 1'b1, 1'b1, 20);
      // A strictly larger count wins; the unmasked last pixel still closes the region.
      send_pixel(24'hA5A5A5, 1'b1, 1'b0, 20);
      send_pixel(24'h5A5A5A, 1'b1, 1'b0, 20);
      send_pixel(24'h5A5A5A, 1'b1, 1'b0, 20);
      send_pixel(24'h5A5A5A, 1'b0, 1'b1, 20);
      // One channel at a time at its maximum, so the packing order shows.
      send_pixel(24'hFF0000, 1'b1, 1'b0, 20);
      send_pixel(24'h00FF00, 1'b1, 1'b0, 20);
      send_pixel(24'h0000FF, 1'b1, 1'b0, 20);
      send_pixel(24'h00FF00, 1'b1, 1'b1, 20);

      // Random regions. Count saturation needs millions of pixels in one region
      // and is out of reach of a run this long.
      while (pixels_sent < PIXEL_TARGET) begin
         if (pixels_sent >= PIXEL_TARGET - CALM_TAIL) begin
            gaps_on = 1'b0;
         end
         kind    = $urandom_range(0, 9);
         gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
         for (int p = 0; p < 8; p++) begin
            palette[p] = random_color();
         end
         anchor = palette[0];
         if (kind <= 5) begin
            // Few colors, mostly masked: the usual patch.
            colors   = $urandom_range(1, 6);
            span     = $urandom_range(1, 40);
            mask_pct = $urandom_range(50, 100);
            for (int n = 0; n < span; n++) begin
               send_pixel(palette[3'($urandom_range(0, colors - 1))],
                          $urandom_range(1, 100) <= mask_pct, n == span - 1, gap_pct);
            end
         end else if (kind <= 7) begin
            // Mostly distinct colors, enough to fill the table and overrun it,
            // with one recurring color that keeps counting after the table is full.
            span = $urandom_range(45, 64);
            for (int n = 0; n < span; n++) begin
               send_pixel(($urandom_range(0, 4) == 0) ? anchor : random_color(),
                          1'b1, n == span - 1, gap_pct);
            end
         end else if (kind == 8) begin
            // Noise: random colors with a random mask.
            span = $urandom_range(1, 20);
            for (int n = 0; n < span; n++) begin
               send_pixel(random_color(), 1'($urandom_range(0, 1)), n == span - 1, gap_pct);
            end
         end else begin
            // Nothing inside the mask.
            span = $urandom_range(1, 10);
            for (int n = 0; n < span; n++) begin
               send_pixel(random_color(), 1'b0, n == span - 1, gap_pct);
            end
         end
      end
      req_chan.valid <= 1'b0;

      // Drain the results, then give the block time to show a stray one.
      while (results_pending != 0) @(posedge clock);
      repeat (TABLE_ENTRIES + 8) @(posedge clock);

      $display("Checked %0d mode results over %0d pixels; %0d regions overran the table.",
               regions_checked, pixels_seen, overflow_regions);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #5_000_000;
      $display("Timed out with %0d results outstanding.", results_pending);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
